FILE: src/knp_pkg.sv
package knp_pkg;

   localparam int ROW_BYTES  = 32;
   localparam int ROW_ADDR_W = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

   localparam int DIV_W      = 16;
   localparam int DIVISOR_W  = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [1:0] REQ_SAMPLE    = 2'd0;
   localparam logic [1:0] REQ_ROW_WRITE = 2'd1;
   localparam logic [1:0] REQ_END_LINE  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_WIDTH    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_X      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_Y      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT_COUNT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_MIRROR_ON    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT_ON    = 3'd5;

   typedef struct packed {
      logic [7:0] row_width;
      logic [4:0] scale_x;
      logic [4:0] scale_y;
      logic [7:0] repeat_count;
      logic       mirror_on;
      logic       invert_on;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_W-1:0]     dividend;
      logic [DIVISOR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_W-1:0]     quotient;
      logic [DIVISOR_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: src/knp_ram.sv
module knp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/knp_divider.sv
module knp_divider
   import knp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;

   logic [DIVISOR_W:0]   trial;
   logic                 fits;

   always_comb begin
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      fits     = trial >= {1'b0, dvs_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quo_in   = div_req.dividend;
         rem_in   = '0;
         dvs_in   = div_req.divisor;
      end else if (busy_ff) begin
         // restoring step, one quotient bit per cycle
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         rem_in   = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: src/knp_cfg.sv
module knp_cfg
   import knp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            REG_ROW_WIDTH:    cfg_in.row_width    = wr_data[7:0];
            REG_SCALE_X:      cfg_in.scale_x      = wr_data[4:0];
            REG_SCALE_Y:      cfg_in.scale_y      = wr_data[4:0];
            REG_REPEAT_COUNT: cfg_in.repeat_count = wr_data[7:0];
            REG_MIRROR_ON:    cfg_in.mirror_on    = wr_data[0];
            REG_INVERT_ON:    cfg_in.invert_on    = wr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width    <= 8'd0;
         cfg_ff.scale_x      <= 5'd1;
         cfg_ff.scale_y      <= 5'd1;
         cfg_ff.repeat_count <= 8'd1;
         cfg_ff.mirror_on    <= 1'b0;
         cfg_ff.invert_on    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: src/knitting_needle_pattern_selector.sv
// Channel  Dir  Handshake              Carries
// req      in   req_tvalid/tready      carriage sample, row byte write, end of line
// rsp      out  rsp_tvalid/tready      edge/select/needle position, row load request
// csr      in   csr_valid/csr_ready    register index and write data
//
// One item at a time; the input is not ready again until the item is through. An edge
// sample on a needle inside the pattern runs two passes of the shared bit-serial divider,
// two limit multiplies, a range check and a row store read; an edge sample outside it runs
// the multiplies and the range check; end of line with a pattern runs one divider pass.
// Synchronous reset clears the state, needle and line counters, output valid and the row store valid bits.
// A result waits in the output register; the next finished item holds the input until it drains.
module knitting_needle_pattern_selector
   import knp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // travel_right, clock_pulse, needle_one_mark,
                                               // byte_index[4:0], byte_value[7:0]
   input  logic [1:0]             req_tuser,   // req_type[1:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [39:0]            rsp_tdata,   // needle_select, needle_position[15:0],
                                               // pattern_row[15:0], zero pad
   output logic [1:0]             rsp_tuser,   // edge_seen, row_load_needed
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_LINE_DIV,
      S_MUL_A,
      S_MUL_B,
      S_RANGE,
      S_DIV_SCALE,
      S_DIV_WRAP,
      S_READ,
      S_SELECT,
      S_FINISH
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic                  req_accept;
   logic                  in_right, in_clock, in_mark;
   logic [4:0]            in_index;
   logic [7:0]            in_value;

   state_type             state_ff, state_in;
   logic                  last_clock_ff, last_clock_in;
   logic                  dir_right_ff, dir_right_in;
   logic                  seen_ff, seen_in;
   logic [15:0]           needle_ff, needle_in;
   logic [15:0]           line_ff, line_in;
   logic [ROW_BYTES-1:0]  valid_ff, valid_in;
   logic [12:0]           prod_ff, prod_in;
   logic [20:0]           limit_ff, limit_in;
   logic [7:0]            stitch_ff, stitch_in;
   logic                  res_edge_ff, res_edge_in;
   logic                  res_sel_ff, res_sel_in;
   logic                  res_load_ff, res_load_in;
   logic [15:0]           res_row_ff, res_row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_edge_ff, rsp_edge_in;
   logic                  rsp_sel_ff, rsp_sel_in;
   logic                  rsp_load_ff, rsp_load_in;
   logic [15:0]           rsp_pos_ff, rsp_pos_in;
   logic [15:0]           rsp_row_ff, rsp_row_in;

   logic                  ram_wr_en, ram_rd_en;
   logic [ROW_ADDR_W-1:0] ram_rd_addr;
   logic [7:0]            ram_rd_data;
   logic [4:0]            stitch_byte;
   logic                  byte_ok;
   logic [15:0]           step_needle;
   logic [4:0]            eff_scale_y;

   assign req_accept  = req_tvalid && req_tready;
   assign req_tready  = state_ff == S_IDLE;
   assign csr_ready   = 1'b1;

   assign in_right    = req_tdata[0];
   assign in_clock    = req_tdata[1];
   assign in_mark     = req_tdata[2];
   assign in_index    = req_tdata[7:3];
   assign in_value    = req_tdata[15:8];

   assign stitch_byte = stitch_ff[7:3];
   assign ram_rd_addr = stitch_byte[ROW_ADDR_W-1:0];
   assign byte_ok     = ({1'b0, stitch_byte} < 6'(ROW_BYTES)) && valid_ff[ram_rd_addr];
   assign eff_scale_y = (cfg.scale_y == 5'd0) ? 5'd1 : cfg.scale_y;
   assign step_needle = in_right ? needle_ff + 16'd1 : needle_ff - 16'd1;

   assign ram_wr_en   = req_accept && req_tuser == REQ_ROW_WRITE
                        && ({1'b0, in_index} < 6'(ROW_BYTES));
   assign ram_rd_en   = state_ff == S_READ;

   knp_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   knp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   knp_ram #(
      .WIDTH (8),
      .DEPTH (ROW_BYTES)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (in_index[ROW_ADDR_W-1:0]),
      .wr_data (in_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      last_clock_in = last_clock_ff;
      dir_right_in  = dir_right_ff;
      seen_in       = seen_ff;
      needle_in     = needle_ff;
      line_in       = line_ff;
      valid_in      = valid_ff;
      prod_in       = prod_ff;
      limit_in      = limit_ff;
      stitch_in     = stitch_ff;
      res_edge_in   = res_edge_ff;
      res_sel_in    = res_sel_ff;
      res_load_in   = res_load_ff;
      res_row_in    = res_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_edge_in   = rsp_edge_ff;
      rsp_sel_in    = rsp_sel_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_row_in    = rsp_row_ff;
      div_req.start    = 1'b0;
      div_req.dividend = needle_ff;
      div_req.divisor  = {3'd0, cfg.scale_x};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_edge_in = 1'b0;
               res_sel_in  = 1'b0;
               res_load_in = 1'b0;
               res_row_in  = '0;
               state_in    = S_FINISH;
               case (req_tuser)
                  REQ_SAMPLE: begin
                     last_clock_in = in_clock;
                     if (in_clock && !last_clock_ff) begin
                        if (in_right != dir_right_ff) begin
                           seen_in = 1'b0;
                        end else begin
                           needle_in = step_needle;
                        end
                        dir_right_in = in_right;
                        if (in_mark && !seen_in) begin
                           seen_in   = 1'b1;
                           needle_in = '0;
                        end
                        res_edge_in = 1'b1;
                        state_in    = S_MUL_A;
                     end
                  end
                  REQ_ROW_WRITE: begin
                     if (ram_wr_en) begin
                        valid_in[in_index[ROW_ADDR_W-1:0]] = 1'b1;
                     end
                  end
                  REQ_END_LINE: begin
                     if (cfg.row_width != 8'd0) begin
                        line_in          = line_ff + 16'd1;
                        div_req.start    = 1'b1;
                        div_req.dividend = line_ff + 16'd1;
                        div_req.divisor  = {3'd0, eff_scale_y};
                        state_in         = S_LINE_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_LINE_DIV: begin
            if (div_rsp.done) begin
               res_load_in = div_rsp.remainder == '0;
               res_row_in  = (div_rsp.remainder == '0) ? div_rsp.quotient : '0;
               state_in    = S_FINISH;
            end
         end
         S_MUL_A: begin
            prod_in  = 13'({5'd0, cfg.row_width} * {8'd0, cfg.scale_x});
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            limit_in = 21'({8'd0, prod_ff} * {13'd0, cfg.repeat_count});
            state_in = S_RANGE;
         end
         S_RANGE: begin
            // negative, past the pattern span, or no pattern: select reads 1
            if (cfg.row_width == 8'd0 || needle_ff[15] || {5'd0, needle_ff} >= limit_ff) begin
               res_sel_in = 1'b1;
               state_in   = S_FINISH;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV_SCALE;
            end
         end
         S_DIV_SCALE: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = cfg.row_width;
               state_in         = S_DIV_WRAP;
            end
         end
         S_DIV_WRAP: begin
            if (div_rsp.done) begin
               stitch_in = cfg.mirror_on ? cfg.row_width - 8'd1 - div_rsp.remainder
                                         : div_rsp.remainder;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            state_in = S_SELECT;
         end
         S_SELECT: begin
            res_sel_in = (byte_ok && ram_rd_data[stitch_ff[2:0]]) ^ cfg.invert_on;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_edge_in  = res_edge_ff;
               rsp_sel_in   = res_sel_ff;
               rsp_load_in  = res_load_ff;
               rsp_pos_in   = needle_ff;
               rsp_row_in   = res_row_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         last_clock_ff <= 1'b0;
         dir_right_ff  <= 1'b0;
         seen_ff       <= 1'b0;
         needle_ff     <= '0;
         line_ff       <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_clock_ff <= last_clock_in;
         dir_right_ff  <= dir_right_in;
         seen_ff       <= seen_in;
         needle_ff     <= needle_in;
         line_ff       <= line_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prod_ff     <= prod_in;
      limit_ff    <= limit_in;
      stitch_ff   <= stitch_in;
      res_edge_ff <= res_edge_in;
      res_sel_ff  <= res_sel_in;
      res_load_ff <= res_load_in;
      res_row_ff  <= res_row_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_load_ff <= rsp_load_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_row_ff, rsp_pos_ff, rsp_sel_ff};
   assign rsp_tuser  = {rsp_load_ff, rsp_edge_ff};

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("item accepted while another is in work");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("edge and row load flagged in one item");

   a_select_needs_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> !rsp_tdata[0])
      else $error("needle select without a rising edge");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_LINE_DIV || state_ff == S_DIV_SCALE
                        || state_ff == S_DIV_WRAP))
      else $error("divider result with no waiting state");
`endif

endmodule
